// ----- rtl/known_bits_transfer_top_defines.svh -----
// assertion macros shared by the checker
`ifndef KNOWN_BITS_TRANSFER_TOP_DEFINES_SVH
`define KNOWN_BITS_TRANSFER_TOP_DEFINES_SVH

// antecedent and consequent in the same cycle
`define KBT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("known bits transfer check failed");

// consequent in the cycle after the antecedent
`define KBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("known bits transfer check failed");

`endif

// ----- rtl/kbt_pkg.sv -----
// types and constants of the known bits transfer unit
package kbt_pkg;

  localparam int unsigned KbtWidth = 32;
  localparam int unsigned KbtAmtW  = 5;

  localparam logic [KbtWidth-1:0] KbtAllOnes = '1;

  typedef enum logic [3:0] {
    KBT_OP_AND  = 4'd0,
    KBT_OP_OR   = 4'd1,
    KBT_OP_XOR  = 4'd2,
    KBT_OP_SHL  = 4'd3,
    KBT_OP_SHR  = 4'd4,
    KBT_OP_SAR  = 4'd5,
    KBT_OP_PASS = 4'd6,
    KBT_OP_ADD  = 4'd7,
    KBT_OP_SUB  = 4'd8
  } kbt_op_t;

  typedef struct packed {
    logic [3:0]          req_type;
    logic [KbtWidth-1:0] a_zero_mask;
    logic [KbtWidth-1:0] a_one_mask;
    logic [KbtWidth-1:0] b_zero_mask;
    logic [KbtWidth-1:0] b_one_mask;
  } kbt_in_t;

  typedef struct packed {
    logic [KbtWidth-1:0] res_zero_mask;
    logic [KbtWidth-1:0] res_one_mask;
    logic                any_known;
  } kbt_out_t;

endpackage

// ----- rtl/known_bits_transfer_top.sv -----
// known bits transfer unit: four-stage pipeline from operand masks to result masks
//
// one item in, one result item out, in order. an item can enter every cycle in which
// in_stall is low, and results leave through out_valid. the pipeline has an input
// register, a prepare stage (bitwise results, known-run mask, shift amount check),
// an execute stage (32-bit adder and barrel shifters) and an output register that also
// forms any_known. each stage holds its own valid bit and moves whenever the stage
// after it is empty or moving, so bubbles are squeezed out and a stalled output still
// lets the earlier stages fill. in_stall is high only while every stage is full and the
// output is stalled. unused operation codes and shifts by a not fully known amount
// give all-zero masks and any_known low.
module known_bits_transfer_top
  import kbt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kbt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output kbt_out_t out_data
);

  // stage enables: a stage loads when it is empty or the next one loads
  logic en_o, en3, en2, en1;

  // input register
  logic    v1_r;
  kbt_in_t d1_r;

  // prepare stage register
  typedef struct packed {
    kbt_op_t             op;
    logic [KbtWidth-1:0] lz;      // bitwise result, zero mask
    logic [KbtWidth-1:0] lo;      // bitwise result, one mask
    logic [KbtWidth-1:0] az;
    logic [KbtWidth-1:0] ao;
    logic [KbtAmtW-1:0]  amt;
    logic                amt_ok;
    logic [KbtWidth-1:0] bval;    // adder operand b
    logic                cin;
    logic [KbtWidth-1:0] run;     // low run known in both operands
  } kbt_prep_t;

  logic      v2_r;
  kbt_prep_t d2_r, d2_nxt;

  // execute stage register
  logic                v3_r;
  logic [KbtWidth-1:0] z3_r, z3_nxt;
  logic [KbtWidth-1:0] o3_r, o3_nxt;

  // output register
  logic     out_valid_r;
  kbt_out_t out_data_r, out_data_nxt;

  assign en_o     = !out_valid_r || !out_stall;
  assign en3      = !v3_r || en_o;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // prepare: bitwise ops, shift amount check, known-run mask, adder operands
  always_comb begin
    logic [KbtWidth-1:0] kn;
    logic [KbtWidth-1:0] unk;
    kn  = (d1_r.a_zero_mask | d1_r.a_one_mask) & (d1_r.b_zero_mask | d1_r.b_one_mask);
    unk = ~kn;

    d2_nxt.op     = kbt_op_t'(d1_r.req_type);
    d2_nxt.az     = d1_r.a_zero_mask;
    d2_nxt.ao     = d1_r.a_one_mask;
    d2_nxt.amt    = d1_r.b_one_mask[KbtAmtW-1:0];
    d2_nxt.amt_ok = ((d1_r.b_zero_mask | d1_r.b_one_mask) == KbtAllOnes);
    // subtract takes b inverted, i.e. its zero mask as the value, plus a carry in
    d2_nxt.cin    = (d1_r.req_type == KBT_OP_SUB);
    d2_nxt.bval   = d2_nxt.cin ? d1_r.b_zero_mask : d1_r.b_one_mask;
    // trailing known bits: everything below the lowest unknown bit
    d2_nxt.run    = (unk == '0) ? KbtAllOnes : ((unk ^ (unk - 1'b1)) >> 1);

    d2_nxt.lz = '0;
    d2_nxt.lo = '0;
    case (d1_r.req_type)
      KBT_OP_AND: begin
        d2_nxt.lz = d1_r.a_zero_mask | d1_r.b_zero_mask;
        d2_nxt.lo = d1_r.a_one_mask & d1_r.b_one_mask;
      end
      KBT_OP_OR: begin
        d2_nxt.lz = d1_r.a_zero_mask & d1_r.b_zero_mask;
        d2_nxt.lo = d1_r.a_one_mask | d1_r.b_one_mask;
      end
      KBT_OP_XOR: begin
        d2_nxt.lz = (d1_r.a_one_mask & d1_r.b_one_mask)
                  | (d1_r.a_zero_mask & d1_r.b_zero_mask);
        d2_nxt.lo = (d1_r.a_one_mask & d1_r.b_zero_mask)
                  | (d1_r.a_zero_mask & d1_r.b_one_mask);
      end
      KBT_OP_PASS: begin
        d2_nxt.lz = d1_r.a_zero_mask;
        d2_nxt.lo = d1_r.a_one_mask;
      end
      default: begin
        d2_nxt.lz = '0;
        d2_nxt.lo = '0;
      end
    endcase
  end

  // execute: adder and shifters, result select
  always_comb begin
    logic [KbtWidth-1:0] sum;
    logic [KbtWidth-1:0] top;
    sum = d2_r.ao + d2_r.bval + {{(KbtWidth-1){1'b0}}, d2_r.cin};
    // vacated top bits of a right shift; empty for an amount of zero
    top = ~(KbtAllOnes >> d2_r.amt);

    z3_nxt = '0;
    o3_nxt = '0;
    case (d2_r.op)
      KBT_OP_AND, KBT_OP_OR, KBT_OP_XOR, KBT_OP_PASS: begin
        z3_nxt = d2_r.lz;
        o3_nxt = d2_r.lo;
      end
      KBT_OP_SHL: begin
        if (d2_r.amt_ok) begin
          z3_nxt = (d2_r.az << d2_r.amt) | ~(KbtAllOnes << d2_r.amt);
          o3_nxt = d2_r.ao << d2_r.amt;
        end
      end
      KBT_OP_SHR: begin
        if (d2_r.amt_ok) begin
          z3_nxt = (d2_r.az >> d2_r.amt) | top;
          o3_nxt = d2_r.ao >> d2_r.amt;
        end
      end
      KBT_OP_SAR: begin
        if (d2_r.amt_ok) begin
          z3_nxt = d2_r.az >> d2_r.amt;
          o3_nxt = d2_r.ao >> d2_r.amt;
          // known-one sign wins over known-zero sign
          if (d2_r.ao[KbtWidth-1]) begin
            o3_nxt = o3_nxt | top;
          end else if (d2_r.az[KbtWidth-1]) begin
            z3_nxt = z3_nxt | top;
          end
        end
      end
      KBT_OP_ADD, KBT_OP_SUB: begin
        z3_nxt = d2_r.run & ~sum;
        o3_nxt = d2_r.run & sum;
      end
      default: begin
        z3_nxt = '0;
        o3_nxt = '0;
      end
    endcase
  end

  // output stage: flag from the final masks
  always_comb begin
    out_data_nxt.res_zero_mask = z3_r;
    out_data_nxt.res_one_mask  = o3_r;
    out_data_nxt.any_known     = |(z3_r | o3_r);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en_o) begin
        out_valid_r <= v3_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en1) begin
      d1_r <= in_data;
    end
    if (en2) begin
      d2_r <= d2_nxt;
    end
    if (en3) begin
      z3_r <= z3_nxt;
      o3_r <= o3_nxt;
    end
    if (en_o) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/kbt_checker.sv -----
// port-level checker for the known bits transfer unit and its bind
`include "known_bits_transfer_top_defines.svh"

module kbt_checker
  import kbt_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input kbt_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input kbt_out_t out_data
);

  // flag agrees with the masks it is formed from
  logic flag_ok;
  assign flag_ok = (out_data.any_known == |(out_data.res_zero_mask | out_data.res_one_mask));

  `KBT_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))
  `KBT_ASSERT_NEXT(a_out_hold_valid, out_valid && out_stall, out_valid)
  `KBT_ASSERT_NEXT(a_out_hold_data, out_valid && out_stall, $stable(out_data))
  `KBT_ASSERT_SAME(a_flag_matches, out_valid, flag_ok)
  `KBT_ASSERT_SAME(a_stall_only_backed_up, in_stall, out_valid && out_stall)

endmodule

bind known_bits_transfer_top kbt_checker u_kbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- verif/kbt_tb_pkg.sv -----
// known bits transfer: result-mask predictor and in-order scoreboard
package kbt_tb_pkg;
  import kbt_pkg::*;

  // masks of the result for one item, plus the any-known flag
  function automatic kbt_out_t transfer_masks(kbt_in_t x);
    logic [KbtWidth-1:0] z;
    logic [KbtWidth-1:0] o;
    logic [KbtWidth-1:0] fill;
    logic [KbtWidth-1:0] bz;
    logic [KbtWidth-1:0] bo;
    logic [KbtAmtW-1:0]  amt;
    logic                carry;
    logic                abit;
    logic                bbit;
    logic                sum;
    bit                  run_on;
    kbt_out_t            r;
    z = '0;
    o = '0;
    case (x.req_type)
      KBT_OP_AND: begin
        z = x.a_zero_mask | x.b_zero_mask;
        o = x.a_one_mask & x.b_one_mask;
      end
      KBT_OP_OR: begin
        z = x.a_zero_mask & x.b_zero_mask;
        o = x.a_one_mask | x.b_one_mask;
      end
      KBT_OP_XOR: begin
        o = (x.a_one_mask & x.b_zero_mask) | (x.a_zero_mask & x.b_one_mask);
        z = (x.a_one_mask & x.b_one_mask) | (x.a_zero_mask & x.b_zero_mask);
      end
      KBT_OP_SHL, KBT_OP_SHR, KBT_OP_SAR: begin
        // amount must be fully known; a zero amount falls out of the formulas
        if ((x.b_zero_mask | x.b_one_mask) == KbtAllOnes) begin
          amt  = x.b_one_mask[KbtAmtW-1:0];
          fill = KbtAllOnes << (32 - amt);
          if (x.req_type == KBT_OP_SHL) begin
            o = x.a_one_mask << amt;
            z = (x.a_zero_mask << amt) | ((32'd1 << amt) - 32'd1);
          end else if (x.req_type == KBT_OP_SHR) begin
            o = x.a_one_mask >> amt;
            z = (x.a_zero_mask >> amt) | fill;
          end else begin
            o = x.a_one_mask >> amt;
            z = x.a_zero_mask >> amt;
            if (x.a_one_mask[KbtWidth-1]) begin
              o = o | fill;
            end else if (x.a_zero_mask[KbtWidth-1]) begin
              z = z | fill;
            end
          end
        end
      end
      KBT_OP_PASS: begin
        z = x.a_zero_mask;
        o = x.a_one_mask;
      end
      KBT_OP_ADD, KBT_OP_SUB: begin
        // subtract is add of the inverted b with a carry in
        if (x.req_type == KBT_OP_SUB) begin
          bz    = x.b_one_mask;
          bo    = x.b_zero_mask;
          carry = 1'b1;
        end else begin
          bz    = x.b_zero_mask;
          bo    = x.b_one_mask;
          carry = 1'b0;
        end
        run_on = 1'b1;
        for (int i = 0; i < KbtWidth; i++) begin
          if (run_on && (x.a_zero_mask[i] | x.a_one_mask[i]) && (bz[i] | bo[i])) begin
            abit  = x.a_one_mask[i];
            bbit  = bo[i];
            sum   = abit ^ bbit ^ carry;
            carry = (abit & bbit) | ((abit ^ bbit) & carry);
            if (sum) begin
              o[i] = 1'b1;
            end else begin
              z[i] = 1'b1;
            end
          end else begin
            run_on = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    r.res_zero_mask = z;
    r.res_one_mask  = o;
    r.any_known     = |(z | o);
    return r;
  endfunction

  class mask_checker;
    kbt_out_t    expected_masks[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function void note_input(kbt_in_t item);
      expected_masks.push_back(transfer_masks(item));
    endfunction

    function void check_result(kbt_out_t got);
      kbt_out_t want;
      if (expected_masks.size() == 0) begin
        $error("result with no item outstanding: %h", got);
        failures++;
        return;
      end
      want = expected_masks.pop_front();
      if (got.res_zero_mask !== want.res_zero_mask) begin
        $error("res_zero_mask mismatch: expected %h, actual %h",
               want.res_zero_mask, got.res_zero_mask);
        failures++;
      end
      if (got.res_one_mask !== want.res_one_mask) begin
        $error("res_one_mask mismatch: expected %h, actual %h",
               want.res_one_mask, got.res_one_mask);
        failures++;
      end
      if (got.any_known !== want.any_known) begin
        $error("any_known mismatch: expected %b, actual %b", want.any_known, got.any_known);
        failures++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_masks.size();
    endfunction
  endclass

endpackage

// ----- verif/tb_top.sv -----
// top of the known bits transfer testbench: clock, reset, item source, result sink
module tb_top;
  import kbt_pkg::*;
  import kbt_tb_pkg::*;

  // opcodes the unit does not define, for the out-of-range cases
  localparam logic [3:0] OpUnusedLo = 4'd9;
  localparam logic [3:0] OpUnusedHi = 4'd15;

  // run shape: three random phases after the directed items
  localparam int unsigned PhaseItems  = 376;
  // long receiver hold to fill the pipeline and push back on the source
  localparam int unsigned HoldCycles  = 64;
  // four-stage pipe, so the drain wait covers any straggler
  localparam int unsigned DrainCycles = 12;
  // far beyond the slowest legal run
  localparam int unsigned CycleLimit  = 200000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  kbt_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  kbt_out_t out_data;

  // idle percentages, changed between phases by the stimulus
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // raised once by the stimulus; the sink runs the long hold on its own count
  bit          hold_armed;
  int unsigned cycle_count = 0;

  mask_checker sb;

  known_bits_transfer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 10-unit clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic kbt_in_t item_of(logic [3:0] op, logic [31:0] az, logic [31:0] ao,
                                      logic [31:0] bz, logic [31:0] bo);
    kbt_in_t it;
    it.req_type    = op;
    it.a_zero_mask = az;
    it.a_one_mask  = ao;
    it.b_zero_mask = bz;
    it.b_one_mask  = bo;
    return it;
  endfunction

  // one operand as {zero mask, one mask}; run-biased shapes feed the adder deep
  function automatic logic [63:0] random_operand(bit prefer_run);
    logic [31:0] value;
    logic [31:0] known;
    int unsigned shape;
    int unsigned run_len;
    value = $urandom;
    shape = $urandom_range(0, 9);
    if (prefer_run && $urandom_range(0, 9) < 7) begin
      shape = 3;
    end
    case (shape)
      0: known = '0;
      1: known = '1;
      // conflicting and overlapping bits, taken as they stand
      2: return {$urandom, $urandom};
      3, 4, 5, 6: begin
        // unbroken low run, with scattered known bits above it
        run_len = $urandom_range(1, 32);
        known   = (run_len == 32) ? '1 : ((32'd1 << run_len) - 32'd1);
        known   = known | ($urandom & $urandom);
      end
      default: known = $urandom;
    endcase
    return {known & ~value, known & value};
  endfunction

  function automatic kbt_in_t random_item();
    kbt_in_t     it;
    logic [31:0] amount;
    int unsigned hole;
    bit          arith;
    if ($urandom_range(0, 99) < 6) begin
      it.req_type = 4'($urandom_range(OpUnusedLo, OpUnusedHi));
    end else begin
      it.req_type = 4'($urandom_range(KBT_OP_AND, KBT_OP_SUB));
    end
    arith = (it.req_type == KBT_OP_ADD) || (it.req_type == KBT_OP_SUB);
    {it.a_zero_mask, it.a_one_mask} = random_operand(arith);
    if (it.req_type inside {KBT_OP_SHL, KBT_OP_SHR, KBT_OP_SAR}) begin
      // mostly a fully known amount, upper bits random so it wraps mod 32
      amount         = $urandom;
      it.b_zero_mask = ~amount;
      it.b_one_mask  = amount;
      if ($urandom_range(0, 9) == 0) begin
        // punch a hole so the amount is not fully known
        hole                 = $urandom_range(0, 31);
        it.b_zero_mask[hole] = 1'b0;
        it.b_one_mask[hole]  = 1'b0;
      end
    end else begin
      {it.b_zero_mask, it.b_one_mask} = random_operand(arith);
    end
    return it;
  endfunction

  // offer one item at the falling edge, hold it until taken, then note it
  task automatic send_item(input kbt_in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_input(item);
    @(negedge clk);
  endtask

  // field extremes, every opcode and each corner of the transfer rules
  task automatic run_directed();
    send_item(item_of(KBT_OP_AND, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h00FF_00FF, 32'hFF00_FF00));
    send_item(item_of(KBT_OP_OR, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h00FF_00FF, 32'hFF00_FF00));
    send_item(item_of(KBT_OP_XOR, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h00FF_00FF, 32'hFF00_FF00));
    send_item(item_of(KBT_OP_PASS, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0));
    // nothing known about a, so nothing known out
    send_item(item_of(KBT_OP_PASS, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(item_of(KBT_OP_SHL, 32'h0000_FFFF, 32'hFFFF_0000, ~32'd4, 32'd4));
    send_item(item_of(KBT_OP_SHR, 32'h0000_FFFF, 32'hFFFF_0000, ~32'd31, 32'd31));
    // zero amount passes a through
    send_item(item_of(KBT_OP_SHL, 32'h0000_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0));
    // amount 33 wraps to 1
    send_item(item_of(KBT_OP_SHR, 32'h0000_FFFF, 32'hFFFF_0000, ~32'h21, 32'h21));
    // amount not fully known: rejected
    send_item(item_of(KBT_OP_SHR, 32'h0000_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFE, 32'h0));
    // arithmetic shift with sign known one, known zero, unknown
    send_item(item_of(KBT_OP_SAR, 32'h0000_0000, 32'h8000_00F0, ~32'd8, 32'd8));
    send_item(item_of(KBT_OP_SAR, 32'h8000_0000, 32'h0000_0F00, ~32'd8, 32'd8));
    send_item(item_of(KBT_OP_SAR, 32'h0000_FFFF, 32'h0000_0000, ~32'd8, 32'd8));
    send_item(item_of(KBT_OP_SAR, 32'h0000_0000, 32'h8000_0000, ~32'd31, 32'd31));
    // all-ones plus one wraps to zero
    send_item(item_of(KBT_OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h1));
    // known run limited by b
    send_item(item_of(KBT_OP_ADD, 32'h0000_00F0, 32'h0000_000F, 32'h0000_000A, 32'h0000_0005));
    // zero minus one
    send_item(item_of(KBT_OP_SUB, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFE, 32'h1));
    send_item(item_of(KBT_OP_SUB, 32'h0000_0003, 32'h0000_00FC, 32'hFFFF_0000, 32'h0000_FFFF));
    // bits marked both zero and one
    send_item(item_of(KBT_OP_AND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(item_of(KBT_OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(item_of(KBT_OP_XOR, 32'h0, 32'h0, 32'h0, 32'h0));
    // undefined opcodes give nothing
    send_item(item_of(OpUnusedLo, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(item_of(OpUnusedHi, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  // result sink: take results at the rising edge, pick the next stall at the falling edge
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    in_valid      = 1'b0;
    in_data       = '0;
    rst_n         = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 56;
    hold_armed    = 1'b0;
    sb            = new();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 18;
        end
        default: begin
          // no idling; the sink's long hold lands here while items keep coming
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_armed    = 1'b1;
        end
      endcase
      repeat (PhaseItems) send_item(random_item());
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    // let any extra result show up before the verdict
    repeat (DrainCycles) @(posedge clk);

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/kbt_pkg.sv
rtl/known_bits_transfer_top.sv
rtl/kbt_checker.sv
verif/kbt_tb_pkg.sv
verif/tb_top.sv
